// ===== hdl/platter_speed_ramp_and_decay_defines.svh =====
// Assertion macros shared by the platter speed block.
`ifndef PLATTER_SPEED_RAMP_AND_DECAY_DEFINES_SVH
`define PLATTER_SPEED_RAMP_AND_DECAY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("platter speed assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("platter speed assertion failed");

`endif

// ===== hdl/psrd_pkg.sv =====
// Shared types and constants of the platter speed ramp and decay block.
package psrd_pkg;

    localparam int SPEED_WIDTH_DEF = 16;
    localparam int FRAC_BITS       = 14;
    localparam int TARGET_WIDTH    = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int TARGET_LIM      = 2 << FRAC_BITS;
    localparam int CHANGE_LSB      = 16;
    localparam int SNAP_LSB        = 16;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [CFG_WIDTH-1:0] RAMP_TICKS_RST = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] DECAY_RST      = 16'd65208;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_MOTOR_ON  = 2'd1,
        KIND_MOTOR_OFF = 2'd2,
        KIND_TARGET    = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        REG_RAMP_TICKS = 1'b0,
        REG_DECAY      = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DECAY,
        ST_DIV,
        ST_RAMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] ramp_ticks;
        logic [CFG_WIDTH-1:0] decay_per_tick;
    } t_cfg;

endpackage

// ===== hdl/psrd_regs.sv =====
// APB configuration registers: ramp length and per-tick decay factor.
module psrd_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [psrd_pkg::APB_AW-1:0]       paddr,
    input  logic [psrd_pkg::APB_DW-1:0]       pwdata,
    output logic [psrd_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output psrd_pkg::t_cfg                    o_cfg
);

    psrd_pkg::t_cfg     r_cfg;
    psrd_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = psrd_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_ticks     <= psrd_pkg::RAMP_TICKS_RST;
            r_cfg.decay_per_tick <= psrd_pkg::DECAY_RST;
        end else if (w_wr) begin
            case (w_idx)
                psrd_pkg::REG_RAMP_TICKS: begin
                    r_cfg.ramp_ticks <= pwdata[psrd_pkg::CFG_WIDTH-1:0];
                end
                psrd_pkg::REG_DECAY: begin
                    r_cfg.decay_per_tick <= pwdata[psrd_pkg::CFG_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            psrd_pkg::REG_RAMP_TICKS: prdata[psrd_pkg::CFG_WIDTH-1:0] = r_cfg.ramp_ticks;
            psrd_pkg::REG_DECAY:      prdata[psrd_pkg::CFG_WIDTH-1:0] = r_cfg.decay_per_tick;
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/psrd_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module psrd_div #(
    parameter int DW = 33,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [DW-1:0] r_quo;

    logic [VW:0]   w_trial;
    logic [VW:0]   w_sub;
    logic          w_ge;

    // One subtractor is reused for every quotient bit.
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_sub   = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_sub[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/platter_speed_ramp_and_decay.sv =====
// Top level of the platter speed ramp and decay block.
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_ready   i_kind, i_new_target
//  result    out        o_valid / i_ready   o_speed, o_motor_running
//  config    in         APB psel/penable    paddr, pwdata (prdata on reads)
//
// Motor on, motor off and set target pass through evaluation to the done state.
// A tick with the motor off takes one multiply, then shift and snap.
// A tick while ramping multiplies, then waits for the bit-serial divider, which
// runs SPEED_WIDTH + 17 iterations; a tick that ends the ramp skips both.
// The block takes one event at a time; a finished beat waits in the output
// register, and the sequencer stalls only if a new result meets a full one.
// Reset is synchronous and active low; it clears speed, ramp and motor state.
`include "platter_speed_ramp_and_decay_defines.svh"

module platter_speed_ramp_and_decay #(
    parameter int SPEED_WIDTH = psrd_pkg::SPEED_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [psrd_pkg::APB_AW-1:0]           paddr,
    input  logic [psrd_pkg::APB_DW-1:0]           pwdata,
    output logic [psrd_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready,
    // Event input.
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_kind,
    input  logic signed [psrd_pkg::TARGET_WIDTH-1:0] i_new_target,
    // Result output.
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [SPEED_WIDTH-1:0]         o_speed,
    output logic                                  o_motor_running
);

    // Widths: magnitudes of speed differences need one extra bit, the product
    // adds the 16-bit tick count or decay factor, the target check works in
    // a width wide enough for both the speed and the raw target.
    localparam int SW = SPEED_WIDTH;
    localparam int CW = psrd_pkg::CFG_WIDTH;
    localparam int TW = psrd_pkg::TARGET_WIDTH;
    localparam int MW = SW + 1;
    localparam int PW = MW + CW;
    localparam int RW = SW + 2;
    localparam int XW = ((SW > TW) ? SW : TW) + 2;

    localparam logic signed [XW-1:0] SMAX =
        $signed({{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}});
    localparam logic signed [XW-1:0] SMIN =
        $signed({{(XW-SW+1){1'b1}}, {(SW-1){1'b0}}});
    localparam logic signed [XW-1:0] TLIM = XW'(psrd_pkg::TARGET_LIM);

    psrd_pkg::t_cfg   w_cfg;

    psrd_pkg::t_state r_state, n_state;
    psrd_pkg::t_kind  r_kind, n_kind;
    logic signed [TW-1:0] r_target, n_target;

    // Architectural state of the platter model.
    logic signed [SW-1:0] r_speed, n_speed;
    logic signed [SW-1:0] r_origin, n_origin;
    logic signed [SW-1:0] r_goal, n_goal;
    logic [CW-1:0]        r_ticks, n_ticks;
    logic                 r_motor, n_motor;

    // Working registers of the sequencer.
    logic                 r_ramp_mode, n_ramp_mode;
    logic                 r_diff_neg, n_diff_neg;
    logic [MW-1:0]        r_mul_a, n_mul_a;
    logic [CW-1:0]        r_mul_b, n_mul_b;
    logic [PW-1:0]        r_prod, n_prod;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic signed [SW-1:0] r_out_speed, n_out_speed;
    logic                 r_out_motor, n_out_motor;

    logic                 w_accept;
    logic                 w_out_free;
    logic [CW-1:0]        w_len;
    logic [CW-1:0]        w_ticks_inc;
    logic                 w_ramp_end;
    logic signed [MW-1:0] w_ramp_diff;
    logic [MW-1:0]        w_ramp_mag;
    logic signed [MW-1:0] w_speed_ext;
    logic [MW-1:0]        w_speed_mag;
    logic signed [XW-1:0] w_t_ext;
    logic signed [XW-1:0] w_t_clamp;
    logic signed [XW-1:0] w_t_satx;
    logic signed [SW-1:0] w_t_sat;
    logic signed [MW-1:0] w_tgt_diff;
    logic [MW-1:0]        w_tgt_mag;
    logic                 w_tgt_big;
    logic [PW-1:0]        w_prod;
    logic [SW-1:0]        w_decay_mag;
    logic                 w_snap;
    logic                 w_div_start;
    logic                 w_div_busy;
    logic [PW-1:0]        w_div_quo;
    logic [MW-1:0]        w_q;
    logic signed [RW-1:0] w_ramp_sum;
    logic                 w_ramp_fits;
    logic signed [SW-1:0] w_ramp_speed;

    psrd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The divider takes the product straight from the multiplier, so its
    // dividend register is the pipeline register after the multiply.
    psrd_div #(
        .DW (PW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_len),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_quo)
    );

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // A ramp length of zero behaves as one tick.
    assign w_len       = (w_cfg.ramp_ticks == '0) ? CW'(1) : w_cfg.ramp_ticks;
    assign w_ticks_inc = (r_ticks < w_len) ? (r_ticks + CW'(1)) : r_ticks;
    assign w_ramp_end  = (w_ticks_inc >= w_len);

    // Distance from the ramp origin to the goal, as sign and magnitude.
    assign w_ramp_diff = $signed({r_goal[SW-1], r_goal}) - $signed({r_origin[SW-1], r_origin});
    assign w_ramp_mag  = w_ramp_diff[MW-1] ? MW'(-w_ramp_diff) : MW'(w_ramp_diff);

    assign w_speed_ext = $signed({r_speed[SW-1], r_speed});
    assign w_speed_mag = r_speed[SW-1] ? MW'(-w_speed_ext) : MW'(w_speed_ext);

    // Target: clamp to plus or minus 2.0, then to the speed range.
    assign w_t_ext   = XW'(r_target);
    assign w_t_clamp = (w_t_ext > TLIM) ? TLIM : ((w_t_ext < -TLIM) ? -TLIM : w_t_ext);
    assign w_t_satx  = (w_t_clamp > SMAX) ? SMAX : ((w_t_clamp < SMIN) ? SMIN : w_t_clamp);
    assign w_t_sat   = w_t_satx[SW-1:0];

    // With the motor on, a target move of more than 16 LSB restarts the ramp.
    assign w_tgt_diff = $signed({w_t_sat[SW-1], w_t_sat}) - $signed({r_goal[SW-1], r_goal});
    assign w_tgt_mag  = w_tgt_diff[MW-1] ? MW'(-w_tgt_diff) : MW'(w_tgt_diff);
    assign w_tgt_big  = (w_tgt_mag > MW'(psrd_pkg::CHANGE_LSB));

    // The single multiplier: distance times ticks, or speed times decay.
    assign w_prod = PW'(r_mul_a) * PW'(r_mul_b);

    // Decay: drop the Q0.16 fraction and snap small speeds to rest.
    assign w_decay_mag = r_prod[SW+CW-1:CW];
    assign w_snap      = (w_decay_mag <= SW'(psrd_pkg::SNAP_LSB));

    // Ramp: origin plus or minus the truncated quotient, then saturate.
    assign w_q          = w_div_quo[MW-1:0];
    assign w_ramp_sum   = r_diff_neg ?
                          ($signed(RW'(r_origin)) - $signed({1'b0, w_q})) :
                          ($signed(RW'(r_origin)) + $signed({1'b0, w_q}));
    assign w_ramp_fits  = (w_ramp_sum[RW-1:SW-1] == '0) || (w_ramp_sum[RW-1:SW-1] == '1);
    assign w_ramp_speed = w_ramp_fits ? w_ramp_sum[SW-1:0] :
                          (w_ramp_sum[RW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

    assign w_div_start = (r_state == psrd_pkg::ST_MUL) && r_ramp_mode;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            psrd_pkg::ST_IDLE: begin
                if (w_accept) n_state = psrd_pkg::ST_EVAL;
            end
            psrd_pkg::ST_EVAL: begin
                case (r_kind)
                    psrd_pkg::KIND_TICK: begin
                        if (r_motor && w_ramp_end) n_state = psrd_pkg::ST_DONE;
                        else                       n_state = psrd_pkg::ST_MUL;
                    end
                    default: n_state = psrd_pkg::ST_DONE;
                endcase
            end
            psrd_pkg::ST_MUL: begin
                n_state = r_ramp_mode ? psrd_pkg::ST_DIV : psrd_pkg::ST_DECAY;
            end
            psrd_pkg::ST_DIV: begin
                if (!w_div_busy) n_state = psrd_pkg::ST_RAMP;
            end
            psrd_pkg::ST_DECAY: n_state = psrd_pkg::ST_DONE;
            psrd_pkg::ST_RAMP:  n_state = psrd_pkg::ST_DONE;
            psrd_pkg::ST_DONE: begin
                if (w_out_free) n_state = psrd_pkg::ST_IDLE;
            end
            default: n_state = psrd_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates driven by the sequencer state.
    always_comb begin
        n_kind      = r_kind;
        n_target    = r_target;
        n_speed     = r_speed;
        n_origin    = r_origin;
        n_goal      = r_goal;
        n_ticks     = r_ticks;
        n_motor     = r_motor;
        n_ramp_mode = r_ramp_mode;
        n_diff_neg  = r_diff_neg;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_prod      = r_prod;
        n_out_speed = r_out_speed;
        n_out_motor = r_out_motor;
        n_out_valid = r_out_valid && !i_ready;

        case (r_state)
            psrd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_kind   = psrd_pkg::t_kind'(i_kind);
                    n_target = i_new_target;
                end
            end
            psrd_pkg::ST_EVAL: begin
                case (r_kind)
                    psrd_pkg::KIND_TICK: begin
                        if (r_motor) begin
                            n_ticks     = w_ticks_inc;
                            n_ramp_mode = 1'b1;
                            n_diff_neg  = w_ramp_diff[MW-1];
                            n_mul_a     = w_ramp_mag;
                            n_mul_b     = w_ticks_inc;
                            if (w_ramp_end) n_speed = r_goal;
                        end else begin
                            n_ramp_mode = 1'b0;
                            n_mul_a     = w_speed_mag;
                            n_mul_b     = w_cfg.decay_per_tick;
                        end
                    end
                    psrd_pkg::KIND_MOTOR_ON: begin
                        n_motor  = 1'b1;
                        n_origin = r_speed;
                        n_ticks  = '0;
                    end
                    psrd_pkg::KIND_MOTOR_OFF: begin
                        n_motor = 1'b0;
                    end
                    psrd_pkg::KIND_TARGET: begin
                        if (r_motor && w_tgt_big) begin
                            n_origin = r_speed;
                            n_ticks  = '0;
                        end
                        n_goal = w_t_sat;
                    end
                    default: begin
                    end
                endcase
            end
            psrd_pkg::ST_MUL: begin
                n_prod = w_prod;
            end
            psrd_pkg::ST_DECAY: begin
                if (w_snap)              n_speed = '0;
                else if (r_speed[SW-1])  n_speed = -$signed(w_decay_mag);
                else                     n_speed = $signed(w_decay_mag);
            end
            psrd_pkg::ST_RAMP: begin
                n_speed = w_ramp_speed;
            end
            psrd_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_speed = r_speed;
                    n_out_motor = r_motor;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psrd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_speed     <= '0;
            r_origin    <= '0;
            r_goal      <= '0;
            r_ticks     <= '0;
            r_motor     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_speed     <= n_speed;
            r_origin    <= n_origin;
            r_goal      <= n_goal;
            r_ticks     <= n_ticks;
            r_motor     <= n_motor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_target    <= n_target;
        r_ramp_mode <= n_ramp_mode;
        r_diff_neg  <= n_diff_neg;
        r_mul_a     <= n_mul_a;
        r_mul_b     <= n_mul_b;
        r_prod      <= n_prod;
        r_out_speed <= n_out_speed;
        r_out_motor <= n_out_motor;
    end

    assign o_ready         = (r_state == psrd_pkg::ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_speed         = r_out_speed;
    assign o_motor_running = r_out_motor;

    // The divider is never left running once the sequencer is back at rest.
    `PSRD_ASSERT_IMP(a_idle_div_quiet, i_clk, i_rst_n, r_state == psrd_pkg::ST_IDLE, !w_div_busy)
    // An accepted event always leaves the sequencer busy in the following cycle.
    `PSRD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // Division only serves a ramp step, which needs the motor on.
    `PSRD_ASSERT_IMP(a_div_ramp_only, i_clk, i_rst_n, r_state == psrd_pkg::ST_DIV, r_ramp_mode && r_motor)

endmodule

// ===== verif/tb_platter_speed_ramp_and_decay.sv =====
// Self-checking testbench for the platter speed ramp and decay block.
`timescale 1ns / 100ps

module tb_platter_speed_ramp_and_decay;

    // The block is built at its default speed width, and the predictor works at the same width.
    localparam int     SPD_W        = psrd_pkg::SPEED_WIDTH_DEF;
    localparam int     TGT_W        = psrd_pkg::TARGET_WIDTH;
    localparam int     CFG_W        = psrd_pkg::CFG_WIDTH;
    localparam longint SPD_MAX      = (longint'(1) << (SPD_W - 1)) - 1;
    localparam longint SPD_MIN      = -SPD_MAX - 1;
    localparam int     IDLE_PCT     = 25;
    // This is the long receiver hold-off. It fills the block and the output register,
    // so the input has to stall.
    localparam int     SQUEEZE_LEN  = 300;
    // The slowest event is a ramp tick, which waits on the divider. The settle pause
    // is set well above it.
    localparam int     SETTLE_LEN   = 4 * (SPD_W + 23);
    localparam int     PHASE_EVENTS = 75;
    localparam int     PHASES       = 6;
    localparam int     SQUEEZE_PHASE = 3;

    typedef struct {
        psrd_pkg::t_kind         kind;
        logic signed [TGT_W-1:0] target;
    } t_platter_event;

    typedef struct {
        logic signed [SPD_W-1:0] speed;
        logic                    running;
    } t_platter_reading;

    // Every input of the block is given a known value from time zero.
    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           psel         = 1'b0;
    logic                           penable      = 1'b0;
    logic                           pwrite       = 1'b0;
    logic [psrd_pkg::APB_AW-1:0]    paddr        = '0;
    logic [psrd_pkg::APB_DW-1:0]    pwdata       = '0;
    logic [psrd_pkg::APB_DW-1:0]    prdata;
    logic                           pready;
    logic                           i_valid      = 1'b0;
    logic                           o_ready;
    logic [1:0]                     i_kind       = '0;
    logic signed [TGT_W-1:0]        i_new_target = '0;
    logic                           o_valid;
    logic                           i_ready      = 1'b0;
    logic signed [SPD_W-1:0]        o_speed;
    logic                           o_motor_running;

    // These are the events waiting to be driven and the readings expected back, oldest first.
    t_platter_event   event_backlog[$];
    t_platter_reading expected_readings[$];
    int               events_queued   = 0;
    int               events_accepted = 0;
    int               mismatches      = 0;

    // These flags control the traffic. They are changed only with nonblocking assignments.
    bit steady_flow  = 1'b0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;
    int hold_left    = 0;

    // This is the predictor's copy of the platter state and the two registers.
    logic signed [SPD_W-1:0] model_speed  = '0;
    logic signed [SPD_W-1:0] model_origin = '0;
    logic signed [SPD_W-1:0] model_goal   = '0;
    logic [CFG_W-1:0]        model_ticks  = '0;
    bit                      model_motor  = 1'b0;
    logic [CFG_W-1:0]        cfg_ramp_ticks = psrd_pkg::RAMP_TICKS_RST;
    logic [CFG_W-1:0]        cfg_decay      = psrd_pkg::DECAY_RST;

    platter_speed_ramp_and_decay #(
        .SPEED_WIDTH(SPD_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_new_target    (i_new_target),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_speed         (o_speed),
        .o_motor_running (o_motor_running)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint pin_to_range(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // This function applies one event to the platter state and returns the reading the
    // block must report.
    function automatic t_platter_reading advance_platter(psrd_pkg::t_kind kind,
                                                         logic signed [TGT_W-1:0] target);
        longint           span;
        longint           diff;
        longint           step;
        longint           aim;
        longint           scaled;
        t_platter_reading reading;
        // A ramp length of zero is treated as one tick.
        span = (cfg_ramp_ticks == 0) ? 1 : longint'(cfg_ramp_ticks);
        case (kind)
            psrd_pkg::KIND_TICK: begin
                if (model_motor) begin
                    // The ramp counter saturates at the ramp length. A shortened ramp
                    // therefore lands on the goal at once.
                    if (longint'(model_ticks) < span) begin
                        model_ticks = model_ticks + 1'b1;
                    end
                    if (longint'(model_ticks) >= span) begin
                        model_speed = model_goal;
                    end else begin
                        diff = longint'(model_goal) - longint'(model_origin);
                        // The quotient is truncated toward zero, so it is worked out on
                        // the magnitude.
                        step = magnitude(diff) * longint'(model_ticks) / span;
                        scaled = (diff < 0) ? longint'(model_origin) - step
                                            : longint'(model_origin) + step;
                        model_speed = SPD_W'(pin_to_range(scaled, SPD_MIN, SPD_MAX));
                    end
                end else begin
                    // This is the coast-down. The magnitude is scaled by the Q0.16 factor
                    // and snapped to zero once it is tiny.
                    scaled = (magnitude(longint'(model_speed)) * longint'(cfg_decay)) >>> 16;
                    if (scaled <= psrd_pkg::SNAP_LSB) begin
                        model_speed = '0;
                    end else begin
                        model_speed = SPD_W'((model_speed < 0) ? -scaled : scaled);
                    end
                end
            end
            psrd_pkg::KIND_MOTOR_ON: begin
                // Motor on always restarts the ramp, even when the motor is already on.
                model_motor  = 1'b1;
                model_origin = model_speed;
                model_ticks  = '0;
            end
            psrd_pkg::KIND_MOTOR_OFF: begin
                model_motor = 1'b0;
            end
            default: begin
                aim = pin_to_range(longint'(target), -psrd_pkg::TARGET_LIM,
                                   psrd_pkg::TARGET_LIM);
                aim = pin_to_range(aim, SPD_MIN, SPD_MAX);
                // With the motor on, a real change of target restarts the ramp from the
                // present speed. A change within the dead band leaves the ramp running.
                if (model_motor &&
                    magnitude(aim - longint'(model_goal)) > psrd_pkg::CHANGE_LSB) begin
                    model_origin = model_speed;
                    model_ticks  = '0;
                end
                model_goal = SPD_W'(aim);
            end
        endcase
        reading.speed   = model_speed;
        reading.running = model_motor;
        return reading;
    endfunction

    // The driver offers one beat at a time. At an acceptance edge it predicts the
    // reading and, unless it idles, presents the next event at once.
    always @(posedge i_clk) begin
        t_platter_event next_beat;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_readings.push_back(
                    advance_platter(psrd_pkg::t_kind'(i_kind), i_new_target));
                events_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (event_backlog.size() != 0 &&
                    (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                    next_beat = event_backlog.pop_front();
                    i_valid      <= 1'b1;
                    i_kind       <= next_beat.kind;
                    i_new_target <= next_beat.target;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // The monitor checks each result beat against the oldest expectation. It also
    // drives i_ready: random stalls, or one long counted hold-off when asked for one.
    always @(posedge i_clk) begin
        t_platter_reading want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result beat, speed %0d motor %0b",
                             $time, o_speed, o_motor_running);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (o_speed !== want.speed) begin
                        $display("%0t: speed mismatch, expected %0d, actual %0d",
                                 $time, want.speed, o_speed);
                        mismatches++;
                    end
                    if (o_motor_running !== want.running) begin
                        $display("%0t: motor_running mismatch, expected %0b, actual %0b",
                                 $time, want.running, o_motor_running);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (squeeze_req && !squeeze_done) begin
                squeeze_done <= 1'b1;
                hold_left    <= SQUEEZE_LEN;
                i_ready      <= 1'b0;
            end else begin
                i_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // An APB write has a setup phase and then an access phase. The register is written
    // at the edge where the access completes.
    task automatic write_register(psrd_pkg::t_reg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= psrd_pkg::APB_AW'(4 * int'(idx));
        pwdata  <= psrd_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            psrd_pkg::REG_RAMP_TICKS: cfg_ramp_ticks = value;
            default:                  cfg_decay      = value;
        endcase
    endtask

    task automatic queue_event(psrd_pkg::t_kind kind, logic signed [TGT_W-1:0] target);
        t_platter_event ev;
        ev.kind   = kind;
        ev.target = target;
        event_backlog.push_back(ev);
        events_queued++;
    endtask

    // This task waits until every queued event has been taken and answered. It then lets
    // the block settle before the next register write.
    task automatic finish_phase();
        while (events_accepted != events_queued || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    function automatic logic signed [TGT_W-1:0] pick_target();
        // Half the targets are near zero, so that the coast-down reaches the snap region
        // quickly. The other half use the full range.
        if ($urandom_range(1) == 0) begin
            return TGT_W'($urandom_range(96)) - TGT_W'(48);
        end
        return TGT_W'($urandom);
    endfunction

    // Most of the random traffic is made of whole motor episodes with random content:
    // aim, start, ramp ticks, an optional retarget near the dead band, stop, coast.
    // The rest is loose events in any order.
    task automatic queue_random_events(int count);
        int                      added;
        int                      burst;
        logic signed [TGT_W-1:0] aim;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 80) begin
                aim = pick_target();
                queue_event(psrd_pkg::KIND_TARGET, aim);
                queue_event(psrd_pkg::KIND_MOTOR_ON, TGT_W'($urandom));
                burst = $urandom_range(1, 8);
                repeat (burst) queue_event(psrd_pkg::KIND_TICK, TGT_W'($urandom));
                added += burst + 2;
                if ($urandom_range(1) == 1) begin
                    // The step is at most 18 LSB either way, around the 16 LSB dead band edge.
                    aim = aim + TGT_W'($urandom_range(36)) - TGT_W'(18);
                    queue_event(psrd_pkg::KIND_TARGET, aim);
                    burst = $urandom_range(0, 6);
                    repeat (burst) queue_event(psrd_pkg::KIND_TICK, TGT_W'($urandom));
                    added += burst + 1;
                end
                queue_event(psrd_pkg::KIND_MOTOR_OFF, TGT_W'($urandom));
                burst = $urandom_range(0, 10);
                repeat (burst) queue_event(psrd_pkg::KIND_TICK, TGT_W'($urandom));
                added += burst + 1;
            end else begin
                queue_event(psrd_pkg::t_kind'($urandom_range(3)), TGT_W'($urandom));
                added++;
            end
        end
    endtask

    // This is the run limit, set several times above the slowest correct run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        // The phases cover a zero ramp, the extreme register values, a one-tick ramp,
        // a short steady phase with the squeeze, a long ramp, and one random setting.
        int ramp_plan  [PHASES];
        int decay_plan [PHASES];
        ramp_plan  = '{0, 65535, 1, 12, 1000, 0};
        decay_plan = '{65535, 0, 32768, 65208, 50000, 0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // This directed opening uses a four-tick ramp and a fast decay.
        write_register(psrd_pkg::REG_RAMP_TICKS, 16'd4);
        write_register(psrd_pkg::REG_DECAY, 16'd40000);
        queue_event(psrd_pkg::KIND_TICK, '0);                     // coast at rest
        queue_event(psrd_pkg::KIND_MOTOR_OFF, '0);                // off while already off
        queue_event(psrd_pkg::KIND_TARGET, 16'sh7FFF);            // largest target, motor off
        queue_event(psrd_pkg::KIND_MOTOR_ON, '0);
        repeat (5) queue_event(psrd_pkg::KIND_TICK, '0);          // ramp up, then past the end
        queue_event(psrd_pkg::KIND_TARGET, 16'sh7FFF - 16'sd10);  // inside the dead band
        queue_event(psrd_pkg::KIND_TICK, '0);
        queue_event(psrd_pkg::KIND_TARGET, 16'sh8000);            // most negative, restarts ramp
        repeat (2) queue_event(psrd_pkg::KIND_TICK, '0);
        queue_event(psrd_pkg::KIND_MOTOR_ON, 16'shFFFF);          // restart while already on
        queue_event(psrd_pkg::KIND_TICK, '0);
        queue_event(psrd_pkg::KIND_MOTOR_OFF, '0);
        repeat (8) queue_event(psrd_pkg::KIND_TICK, '0);          // negative coast-down
        finish_phase();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) begin
                ramp_plan[p]  = $urandom_range(2, 24);
                decay_plan[p] = $urandom_range(65535);
            end
            write_register(psrd_pkg::REG_RAMP_TICKS, CFG_W'(ramp_plan[p]));
            write_register(psrd_pkg::REG_DECAY, CFG_W'(decay_plan[p]));
            // One phase runs with no random idling on either side. The receiver's long
            // hold-off falls in that phase, while the sender keeps pushing.
            steady_flow <= (p == SQUEEZE_PHASE);
            squeeze_req <= (p == SQUEEZE_PHASE);
            queue_random_events(PHASE_EVENTS);
            finish_phase();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
